@@ src/wma_pkg.sv @@
// Package for the weighted moving average alert block.
// Holds widths, register index codes, alert class codes and the stage enable struct.
// No dependencies.
package wma_pkg;

   localparam int SAMPLE_W = 20;
   localparam int CSR_IDX_W = 2;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAUTION   = 2'd0,
      CSR_ALERT     = 2'd1,
      CSR_EMERGENCY = 2'd2
   } csr_index_type;

   // alert class codes
   typedef enum logic [1:0] {
      CLASS_NONE      = 2'd0,
      CLASS_CAUTION   = 2'd1,
      CLASS_ALERT     = 2'd2,
      CLASS_EMERGENCY = 2'd3
   } alert_class_type;

   // threshold values after reset, Q16.4
   localparam logic [SAMPLE_W-1:0] CAUTION_RESET   = 20'd16000;
   localparam logic [SAMPLE_W-1:0] ALERT_RESET     = 20'd80000;
   localparam logic [SAMPLE_W-1:0] EMERGENCY_RESET = 20'd480000;

   // load enables for the three divider stages
   typedef struct packed {
      logic mul;
      logic fix;
      logic out;
   } wma_stage_en_type;

endpackage

@@ src/wma_cell.sv @@
// One cell of the sample shift line: holds one window entry.
// Depends on wma_pkg for the sample width.
module wma_cell
   import wma_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  logic [SAMPLE_W-1:0] sample_prev,
   output logic [SAMPLE_W-1:0] sample_out
);

   logic [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0] sample_in;

   // take the neighbor's sample on a shift, else hold
   assign sample_in = shift ? sample_prev : sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in;
      end
   end

   assign sample_out = sample_ff;

endmodule

@@ src/wma_div.sv @@
// Constant divider: reciprocal multiply, back multiply, one correction step.
// Three registered stages; depends on wma_pkg for the stage enable struct.
module wma_div
   import wma_pkg::*;
#(
   parameter int SUM_W   = 25,
   parameter int DIVISOR = 30,
   parameter int OUT_W   = 20
)
(
   input  logic             clock,
   input  wma_stage_en_type en,
   input  logic [SUM_W-1:0] sum,
   output logic [OUT_W-1:0] quot
);

   // reciprocal rounded down; the estimate is at most one below the quotient
   localparam longint unsigned MULT_L = (64'd1 << SUM_W) / DIVISOR;
   localparam int MULT_W = $clog2(MULT_L + 1);
   localparam int PROD_W = SUM_W + MULT_W;
   localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_L);
   localparam logic [SUM_W-1:0] DIV_C = SUM_W'(DIVISOR);

   logic [SUM_W-1:0]  sum_b_ff;
   logic [PROD_W-1:0] prod_b_ff, prod_b_in;
   logic [SUM_W-1:0]  sum_c_ff;
   logic [MULT_W-1:0] quot_c_ff, quot_c_in;
   logic [SUM_W-1:0]  back_c_ff, back_c_in;
   logic [SUM_W-1:0]  rem;
   logic [MULT_W:0]   quot_fix;
   logic [OUT_W-1:0]  quot_d_ff, quot_d_in;

   // estimate the quotient
   assign prod_b_in = PROD_W'(sum) * PROD_W'(MULT);

   // multiply the estimate back
   assign quot_c_in = prod_b_ff[SUM_W +: MULT_W];
   assign back_c_in = SUM_W'(SUM_W'(quot_c_in) * DIV_C);

   // correct the estimate by one where the remainder reaches the divisor
   assign rem       = sum_c_ff - back_c_ff;
   assign quot_fix  = {1'b0, quot_c_ff} + {{MULT_W{1'b0}}, (rem >= DIV_C)};
   assign quot_d_in = OUT_W'(quot_fix);

   always_ff @(posedge clock) begin
      if (en.mul) begin
         sum_b_ff  <= sum;
         prod_b_ff <= prod_b_in;
      end
      if (en.fix) begin
         sum_c_ff  <= sum_b_ff;
         quot_c_ff <= quot_c_in;
         back_c_ff <= back_c_in;
      end
      if (en.out) begin
         quot_d_ff <= quot_d_in;
      end
   end

   assign quot = quot_d_ff;

endmodule

@@ src/weighted_moving_average_alert.sv @@
// Top level: sample shift line of cells, running sums, alert class and two dividers.
// Depends on wma_pkg, wma_cell and wma_div.
//
//  channel | ports                               | direction | handshake
//  --------+-------------------------------------+-----------+--------------
//  req     | req_sample                          | in        | valid / stall
//  rsp     | rsp_window_mean, rsp_weighted_mean, | out       | valid / stall
//          | rsp_alert_class                     |           |
//  csr     | csr_index, csr_data                 | in        | valid / ready
//
// One request per cycle sustained while rsp_stall is low; a response is registered through
// the state update stage and then the three stages of the constant dividers.
// Synchronous reset clears the window, both sums, the pipeline and sets the thresholds.
// Each stage advances while the one after it is empty or moving, so a held response
// still lets requests into empty stages behind it. csr_ready is always high.
module weighted_moving_average_alert
   import wma_pkg::*;
#(
   parameter int WINDOW = 30
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [SAMPLE_W-1:0]  req_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [SAMPLE_W-1:0]  rsp_window_mean,
   output logic [SAMPLE_W-1:0]  rsp_weighted_mean,
   output logic [1:0]           rsp_alert_class,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SAMPLE_W-1:0]  csr_data
);

   localparam int WEIGHT_TOTAL = WINDOW * (WINDOW + 1) / 2;
   localparam int PS_W = SAMPLE_W + $clog2(WINDOW);
   localparam int WS_W = SAMPLE_W + $clog2(WEIGHT_TOTAL);
   localparam logic [PS_W-1:0] PS_MAX = PS_W'(WINDOW * ((1 << SAMPLE_W) - 1));

   logic [SAMPLE_W-1:0] tap [WINDOW+1];
   logic                accept;

   logic [SAMPLE_W-1:0] caution_ff, alert_ff, emergency_ff;
   logic [SAMPLE_W-1:0] caution_in, alert_in, emergency_in;

   logic [PS_W-1:0]     plain_sum_ff, plain_sum_in;
   logic [WS_W-1:0]     weighted_sum_ff, weighted_sum_in;
   alert_class_type     class_a_ff, class_a_in;
   alert_class_type     class_b_ff, class_c_ff, class_d_ff;

   logic                valid_a_ff, valid_b_ff, valid_c_ff, valid_d_ff;
   logic                valid_a_in, valid_b_in, valid_c_in, valid_d_in;
   logic                ready_a, ready_b, ready_c, ready_d;
   wma_stage_en_type    stage_en;

   // pipeline flow: a stage moves while the next one is empty or moving
   assign ready_d = !valid_d_ff || !rsp_stall;
   assign ready_c = !valid_c_ff || ready_d;
   assign ready_b = !valid_b_ff || ready_c;
   assign ready_a = !valid_a_ff || ready_b;
   assign accept  = req_valid && ready_a;
   assign req_stall = !ready_a;

   assign stage_en.mul = valid_a_ff && ready_b;
   assign stage_en.fix = valid_b_ff && ready_c;
   assign stage_en.out = valid_c_ff && ready_d;

   assign valid_a_in = ready_a ? req_valid  : valid_a_ff;
   assign valid_b_in = ready_b ? valid_a_ff : valid_b_ff;
   assign valid_c_in = ready_c ? valid_b_ff : valid_c_ff;
   assign valid_d_in = ready_d ? valid_c_ff : valid_d_ff;

   // sample shift line, newest in the first cell
   assign tap[0] = req_sample;

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      wma_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift       (accept),
         .sample_prev (tap[i]),
         .sample_out  (tap[i+1])
      );
   end

   // running sums: every entry drops one weight, the new sample enters at full weight
   always_comb begin
      plain_sum_in    = plain_sum_ff;
      weighted_sum_in = weighted_sum_ff;
      if (accept) begin
         weighted_sum_in = weighted_sum_ff - WS_W'(plain_sum_ff)
                           + WS_W'(req_sample) * WS_W'(WINDOW);
         plain_sum_in    = plain_sum_ff - PS_W'(tap[WINDOW]) + PS_W'(req_sample);
      end
   end

   // classify the new sample, highest threshold first
   always_comb begin
      if (req_sample > emergency_ff) begin
         class_a_in = CLASS_EMERGENCY;
      end else if (req_sample > alert_ff) begin
         class_a_in = CLASS_ALERT;
      end else if (req_sample > caution_ff) begin
         class_a_in = CLASS_CAUTION;
      end else begin
         class_a_in = CLASS_NONE;
      end
   end

   // decode threshold writes
   always_comb begin
      caution_in   = caution_ff;
      alert_in     = alert_ff;
      emergency_in = emergency_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CAUTION:   caution_in   = csr_data;
            CSR_ALERT:     alert_in     = csr_data;
            CSR_EMERGENCY: emergency_in = csr_data;
            default:       ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff      <= 1'b0;
         valid_b_ff      <= 1'b0;
         valid_c_ff      <= 1'b0;
         valid_d_ff      <= 1'b0;
         plain_sum_ff    <= '0;
         weighted_sum_ff <= '0;
         caution_ff      <= CAUTION_RESET;
         alert_ff        <= ALERT_RESET;
         emergency_ff    <= EMERGENCY_RESET;
      end else begin
         valid_a_ff      <= valid_a_in;
         valid_b_ff      <= valid_b_in;
         valid_c_ff      <= valid_c_in;
         valid_d_ff      <= valid_d_in;
         plain_sum_ff    <= plain_sum_in;
         weighted_sum_ff <= weighted_sum_in;
         caution_ff      <= caution_in;
         alert_ff        <= alert_in;
         emergency_ff    <= emergency_in;
      end
   end

   // carry the class alongside the divider stages
   always_ff @(posedge clock) begin
      if (accept) begin
         class_a_ff <= class_a_in;
      end
      if (stage_en.mul) begin
         class_b_ff <= class_a_ff;
      end
      if (stage_en.fix) begin
         class_c_ff <= class_b_ff;
      end
      if (stage_en.out) begin
         class_d_ff <= class_c_ff;
      end
   end

   wma_div #(
      .SUM_W   (PS_W),
      .DIVISOR (WINDOW),
      .OUT_W   (SAMPLE_W)
   ) u_plain_div (
      .clock (clock),
      .en    (stage_en),
      .sum   (plain_sum_ff),
      .quot  (rsp_window_mean)
   );

   wma_div #(
      .SUM_W   (WS_W),
      .DIVISOR (WEIGHT_TOTAL),
      .OUT_W   (SAMPLE_W)
   ) u_weighted_div (
      .clock (clock),
      .en    (stage_en),
      .sum   (weighted_sum_ff),
      .quot  (rsp_weighted_mean)
   );

   assign rsp_valid       = valid_d_ff;
   assign rsp_alert_class = class_d_ff;

   // the plain sum never exceeds a window of full-scale samples
   a_plain_sum_range: assert property (@(posedge clock) disable iff (reset)
      plain_sum_ff <= PS_MAX)
      else $error("plain sum out of range");

   // every weight is at least one, so the weighted sum covers the plain sum
   a_weighted_covers_plain: assert property (@(posedge clock) disable iff (reset)
      weighted_sum_ff >= WS_W'(plain_sum_ff))
      else $error("weighted sum below plain sum");

   // a taken request occupies the first stage next cycle
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> valid_a_ff)
      else $error("accepted request lost");

endmodule
